// ===== hdl/ubx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_pkg
// Shared types and constants of the binary frame parser.
// ----------------------------------------------------------------------------
package ubx_pkg;

  localparam logic [7:0] SyncA  = 8'hB5;
  localparam logic [7:0] SyncB  = 8'h62;
  localparam logic [7:0] ClsNav = 8'h01;
  localparam logic [7:0] ClsTim = 8'h0D;
  localparam logic [7:0] IdPos  = 8'h02;
  localparam logic [7:0] IdSol  = 8'h06;
  localparam logic [7:0] IdTm   = 8'h03;
  localparam logic [7:0] Fix2d  = 8'h02;
  localparam logic [7:0] Fix3d  = 8'h03;

  localparam int unsigned NumWords = 10;

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_HEADER, PH_PAYLOAD, PH_CKA, PH_CKB
  } phase_e;

  typedef enum logic [2:0] {
    ST_CKERR = 3'd0, ST_POS = 3'd1, ST_SOL = 3'd2, ST_TM = 3'd3, ST_OTHER = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_SINGLE, CMD_POS, CMD_SOL, CMD_TM
  } cmd_e;

  // request from the front part to the back part
  typedef struct packed {
    cmd_e                    cmd;
    status_e                 status;
    logic [31:0]             tag;
    logic [NumWords-1:0][31:0] words;
    logic [7:0]              sol_fix;
    logic [7:0]              sol_flags;
    logic [7:0]              sol_sats;
  } req_t;

  function automatic logic [3:0] tm_field(input logic [4:0] off);
    case (off)
      5'd0:  tm_field = 4'd0;
      5'd1:  tm_field = 4'd1;
      5'd2, 5'd3: tm_field = 4'd2;
      5'd4, 5'd5: tm_field = 4'd3;
      5'd6, 5'd7: tm_field = 4'd4;
      default: tm_field = 4'(5 + ((off - 5'd8) >> 2));
    endcase
  endfunction

  function automatic logic [1:0] tm_lane(input logic [4:0] off);
    case (off)
      5'd0, 5'd1, 5'd2, 5'd4, 5'd6: tm_lane = 2'd0;
      5'd3, 5'd5, 5'd7: tm_lane = 2'd1;
      default: tm_lane = off[1:0];
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ubx_frame_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_frame_parser_unit
// Binary frame parser with Fletcher-8 check and field result runs.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                | tuser  | tlast
// s_axis  | in  | rx_byte[7:0]                         | -      | -
// m_axis  | out | word_index,value,fix_type,sat_count  | status | last of run
//
// One byte accepted per cycle while the request queue has room.
// A frame's run drains one result per cycle, while m_axis_tready is high, behind the byte parser.
// The input stalls only when QueueDepth frame runs are pending.
// Reset returns the parser to sync hunting and clears the fix state.
// ----------------------------------------------------------------------------
module ubx_frame_parser_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // word_index[3:0] value[35:4] fix_type[43:36]
                                           // sat_count[51:44] zero[55:52]
  output logic [2:0]       m_axis_tuser,   // status[2:0]
  output logic             m_axis_tlast
);
  import ubx_pkg::*;

  req_t fr_req, q_req;
  logic fr_valid, full, empty, pop, acc;

  assign s_axis_tready = !full;
  assign acc = s_axis_tvalid && s_axis_tready;

  ubx_front u_front (
    .clk_i, .rst_ni, .byte_valid_i(acc), .byte_i(s_axis_tdata),
    .req_o(fr_req), .req_valid_o(fr_valid)
  );

  ubx_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(fr_valid), .push_data_i(fr_req),
    .full_o(full), .empty_o(empty), .pop_i(pop), .pop_data_o(q_req)
  );

  ubx_back u_back (
    .clk_i, .rst_ni, .req_avail_i(!empty), .req_i(q_req), .req_pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_user_o(m_axis_tuser), .out_last_o(m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== hdl/ubx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_front
// Byte parser: sync hunt, header, checksum, field capture; issues requests.
// ----------------------------------------------------------------------------
module ubx_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        byte_valid_i,
  input  wire logic [7:0]  byte_i,
  output ubx_pkg::req_t    req_o,
  output logic             req_valid_o
);
  import ubx_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  cls_q, cls_d, id_q, id_d, sa_q, sa_d, sb_q, sb_d;
  logic [15:0] len_q, len_d, off_q, off_d;
  logic [NumWords-1:0][31:0] w_q, w_d;
  logic [7:0]  sf_q, sf_d, sg_q, sg_d, ss_q, ss_d;
  logic [7:0]  na;
  logic [15:0] off_n;
  logic        is_pos, is_sol, is_tm;
  logic [3:0]  fi;
  logic [1:0]  ln;

  assign is_pos = (cls_q == ClsNav) && (id_q == IdPos);
  assign is_sol = (cls_q == ClsNav) && (id_q == IdSol);
  assign is_tm  = (cls_q == ClsTim) && (id_q == IdTm);
  assign na     = sa_q + byte_i;
  assign off_n  = off_q + 16'd1;
  assign fi     = tm_field(off_q[4:0]);
  assign ln     = tm_lane(off_q[4:0]);

  always_comb begin
    phase_d = phase_q; cls_d = cls_q; id_d = id_q; sa_d = sa_q; sb_d = sb_q;
    len_d = len_q; off_d = off_q; w_d = w_q; sf_d = sf_q; sg_d = sg_q; ss_d = ss_q;
    req_valid_o = 1'b0;
    req_o = '0;
    req_o.tag = {16'd0, cls_q, id_q};
    req_o.words = w_q;
    req_o.sol_fix = sf_q; req_o.sol_flags = sg_q; req_o.sol_sats = ss_q;
    req_o.cmd = CMD_SINGLE;
    req_o.status = ST_CKERR;
    if (byte_valid_i) begin
      case (phase_q)
        PH_SYNC1: if (byte_i == SyncA) phase_d = PH_SYNC2;
        PH_SYNC2: begin
          if (byte_i == SyncB) begin
            phase_d = PH_HEADER; off_d = '0; sa_d = '0; sb_d = '0;
          end else if (byte_i != SyncA) begin
            phase_d = PH_SYNC1;
          end
        end
        PH_HEADER: begin
          sa_d = na; sb_d = sb_q + na;
          case (off_q[1:0])
            2'd0: cls_d = byte_i;
            2'd1: id_d = byte_i;
            2'd2: len_d = {8'd0, byte_i};
            default: len_d = {byte_i, len_q[7:0]};
          endcase
          off_d = off_n;
          if (off_q[1:0] == 2'd3) begin
            off_d = '0; w_d = '0; sf_d = '0; sg_d = '0; ss_d = '0;
            phase_d = ({byte_i, len_q[7:0]} != 16'd0) ? PH_PAYLOAD : PH_CKA;
          end
        end
        PH_PAYLOAD: begin
          sa_d = na; sb_d = sb_q + na;
          if (is_pos) begin
            if (off_q < 16'd16) w_d[off_q[3:2]][off_q[1:0]*8 +: 8] = byte_i;
          end else if (is_sol) begin
            if (off_q == 16'd10) sf_d = byte_i;
            else if (off_q == 16'd11) sg_d = byte_i;
            else if (off_q == 16'd47) ss_d = byte_i;
          end else if (is_tm) begin
            if (off_q < 16'd28) w_d[fi][ln*8 +: 8] = byte_i;
          end
          off_d = off_n;
          if (off_n >= len_q) phase_d = PH_CKA;
        end
        PH_CKA: begin
          if (byte_i == sa_q) phase_d = PH_CKB;
          else begin
            phase_d = PH_SYNC1; req_valid_o = 1'b1;
          end
        end
        PH_CKB: begin
          phase_d = PH_SYNC1; req_valid_o = 1'b1;
          if (byte_i == sb_q) begin
            if (is_pos) begin req_o.cmd = CMD_POS; req_o.status = ST_POS; end
            else if (is_sol) begin req_o.cmd = CMD_SOL; req_o.status = ST_SOL; end
            else if (is_tm) begin req_o.cmd = CMD_TM; req_o.status = ST_TM; end
            else req_o.status = ST_OTHER;
          end
        end
        default: phase_d = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1; cls_q <= '0; id_q <= '0; len_q <= '0; off_q <= '0;
      sa_q <= '0; sb_q <= '0;
    end else begin
      phase_q <= phase_d; cls_q <= cls_d; id_q <= id_d; len_q <= len_d;
      off_q <= off_d; sa_q <= sa_d; sb_q <= sb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; sf_q <= sf_d; sg_q <= sg_d; ss_q <= ss_d;
  end

`ifndef SYNTHESIS
  a_req_only_on_ck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_o |-> (phase_q == PH_CKA || phase_q == PH_CKB)) else $error("req phase");
  a_ckb_after_cka: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q == PH_CKB) |-> $past(phase_q) == PH_CKA) else $error("ckb order");
  a_hunt_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_o |=> phase_q == PH_SYNC1) else $error("no restart");
`endif
endmodule
`default_nettype wire

// ===== hdl/ubx_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_queue
// Short request queue between parser and result sequencer.
// ----------------------------------------------------------------------------
module ubx_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  ubx_pkg::req_t   push_data_i,
  output logic            full_o,
  output logic            empty_o,
  input  wire logic       pop_i,
  output ubx_pkg::req_t   pop_data_o
);
  import ubx_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  req_t           mem_q [Depth];
  logic [Aw-1:0]  wp_q, rp_q;
  logic [Aw:0]    cnt_q;
  logic           do_push, do_pop;

  assign full_o   = cnt_q == (Aw+1)'(Depth);
  assign empty_o  = cnt_q == '0;
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Aw+1)'(Depth)) else $error("queue count");
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o) else $error("queue lost push");
`endif
endmodule
`default_nettype wire

// ===== hdl/ubx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_back
// Result sequencer: holds fix state, emits the run of results per request.
// ----------------------------------------------------------------------------
module ubx_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_avail_i,
  input  ubx_pkg::req_t    req_i,
  output logic             req_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [55:0]      out_data_o,
  output logic [2:0]       out_user_o,
  output logic             out_last_o
);
  import ubx_pkg::*;

  logic [7:0] fix_q, fix_d, sats_q, sats_d;
  logic [3:0] idx_q, idx_d;
  logic [3:0] cnt;
  logic       fire, lastb;
  logic [31:0] val;
  status_e    st;

  always_comb begin
    case (req_i.cmd)
      CMD_POS: cnt = (fix_q == Fix3d) ? 4'd4 : ((fix_q == Fix2d) ? 4'd3 : 4'd1);
      CMD_TM:  cnt = 4'(NumWords);
      default: cnt = 4'd1;
    endcase
  end

  assign lastb = (idx_q + 4'd1) == cnt;
  assign fire  = req_avail_i && out_ready_i;
  assign out_valid_o = req_avail_i;
  assign req_pop_o = fire && lastb;
  assign st = req_i.status;

  always_comb begin
    fix_d = fix_q; sats_d = sats_q;
    if (req_i.cmd == CMD_SOL) begin
      if (req_i.sol_fix >= Fix2d && req_i.sol_flags[0]) begin
        fix_d = req_i.sol_fix; sats_d = req_i.sol_sats;
      end else begin
        fix_d = '0;
      end
    end
  end

  always_comb begin
    case (req_i.cmd)
      CMD_POS: val = (fix_q == Fix3d || fix_q == Fix2d) ? req_i.words[idx_q] : 32'd0;
      CMD_TM:  val = req_i.words[idx_q];
      CMD_SOL: val = 32'd0;
      default: val = req_i.tag;
    endcase
  end

  assign out_data_o = {4'd0, sats_d, fix_d, val, idx_q};
  assign out_user_o = st;
  assign out_last_o = lastb;
  assign idx_d = req_pop_o ? 4'd0 : (fire ? idx_q + 4'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_q <= '0; sats_q <= '0; idx_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (req_pop_o) begin
        fix_q <= fix_d; sats_q <= sats_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_avail_i |-> idx_q < cnt) else $error("index range");
  a_idx_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> idx_q == 4'd0) else $error("index not cleared");
  a_fix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_pop_o |=> $stable(fix_q)) else $error("fix changed");
`endif
endmodule
`default_nettype wire
